### hdl/touch_point_median_debounce_core_macros.svh
// ----------------------------------------------------------------------------
// touch point median debounce: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOUCH_POINT_MEDIAN_DEBOUNCE_CORE_MACROS_SVH
`define TOUCH_POINT_MEDIAN_DEBOUNCE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, off while reset is held
`define TPMD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tpmd check failed");

// next-cycle implication, off while reset is held
`define TPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tpmd check failed");

`else

`define TPMD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/tpmd_pkg.sv
// ----------------------------------------------------------------------------
// tpmd_pkg
// Shared types, constants and the compare-exchange network of the median lanes.
// ----------------------------------------------------------------------------
package tpmd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WIN_DEPTH   = 5;
    localparam int IDX_W       = $clog2(WIN_DEPTH);
    localparam int NUM_LVL     = 5;
    localparam int LVL_W       = $clog2(NUM_LVL);
    localparam int CNT_W       = 4;
    localparam int PRESS_COUNT = 6;

    typedef logic [SAMPLE_W-1:0]                 t_sample;
    typedef logic [WIN_DEPTH-1:0][SAMPLE_W-1:0]  t_win;
    typedef logic [IDX_W-1:0]                    t_idx;
    typedef logic [LVL_W-1:0]                    t_lvl;
    typedef logic [CNT_W-1:0]                    t_cnt;

    localparam t_cnt CNT_LIMIT = t_cnt'(PRESS_COUNT);
    localparam t_idx MED_IDX   = t_idx'(WIN_DEPTH / 2);

    // compare-exchange pairs per level of the five-element network
    localparam t_idx CX_A [NUM_LVL] = '{t_idx'(0), t_idx'(0), t_idx'(0), t_idx'(1), t_idx'(2)};
    localparam t_idx CX_B [NUM_LVL] = '{t_idx'(1), t_idx'(2), t_idx'(1), t_idx'(2), t_idx'(3)};
    localparam t_idx CX_C [NUM_LVL] = '{t_idx'(2), t_idx'(1), t_idx'(2), t_idx'(3), t_idx'(0)};
    localparam t_idx CX_D [NUM_LVL] = '{t_idx'(3), t_idx'(4), t_idx'(3), t_idx'(4), t_idx'(0)};
    // second pair present on every level but the last
    localparam logic [NUM_LVL-1:0] CX_USE2 = 5'b01111;

    // window shift and per-stage load strobes from the pipeline control to a lane
    typedef struct packed {
        logic               shift;
        logic [NUM_LVL-1:0] load;
    } t_lane_ctl;

    // what the lanes and the debounce flag hand to the merge stage
    typedef struct packed {
        t_sample median_x;
        t_sample median_y;
        logic    touch;
    } t_result;

    // order one pair, smaller value to the lower slot
    function automatic t_win cx_pair(input t_win v, input t_idx a, input t_idx b);
        t_win r;
        r = v;
        if (v[a] > v[b]) begin
            r[a] = v[b];
            r[b] = v[a];
        end
        return r;
    endfunction

    // one level of the network; the two pairs of a level are disjoint
    function automatic t_win cx_level(input t_win v, input t_lvl lvl);
        t_win r;
        r = cx_pair(v, CX_A[lvl], CX_B[lvl]);
        if (CX_USE2[lvl]) begin
            r = cx_pair(r, CX_C[lvl], CX_D[lvl]);
        end
        return r;
    endfunction

endpackage

### hdl/touch_point_median_debounce_core.sv
// Path: a word accepted at the input passes the five sort stages, then the
// output register. Throughput: one word per cycle while o_stall is low; the
// X and Y lanes sort in parallel and each network level has its own register
// stage, so nothing is shared.
// Reset (synchronous, active low): windows and press counter clear to zero,
// all stages and the output go empty.
// ----------------------------------------------------------------------------
// touch_point_median_debounce_core
// Five-tap sliding median of X and Y touch samples with pen-down debounce.
// ----------------------------------------------------------------------------
`include "touch_point_median_debounce_core_macros.svh"

module touch_point_median_debounce_core import tpmd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  logic    i_pen_down,
    input  t_sample i_sample_x,
    input  t_sample i_sample_y,
    output logic    o_valid,
    input  logic    i_stall,
    output t_sample o_median_x,
    output t_sample o_median_y,
    output logic    o_touch_valid
);

    logic [NUM_LVL-1:0] r_vld;
    logic [NUM_LVL-1:0] r_tv;
    logic [NUM_LVL-1:0] w_rdy;
    logic [NUM_LVL-1:0] w_vin;
    logic               w_mrdy;
    logic               w_accept;
    t_cnt               r_cnt;
    t_cnt               n_cnt;
    logic               n_touch;
    t_lane_ctl          w_ctl;
    t_result            w_res;

    // ready chain from the output register back to the input
    always_comb begin
        w_rdy[NUM_LVL-1] = !r_vld[NUM_LVL-1] || w_mrdy;
        for (int k = NUM_LVL - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // stage input valids and load strobes
    always_comb begin
        w_vin[0] = i_valid;
        for (int k = 1; k < NUM_LVL; k++) begin
            w_vin[k] = r_vld[k-1];
        end
        w_ctl.load  = w_rdy & w_vin;
        w_ctl.shift = w_ctl.load[0];
    end

    assign w_accept = i_valid && w_rdy[0];
    assign o_stall  = !w_rdy[0];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_LVL; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // press counter: clear on pen up, count up to the limit and hold
    always_comb begin
        priority if (!i_pen_down) begin
            n_cnt = '0;
        end else if (r_cnt < CNT_LIMIT) begin
            n_cnt = r_cnt + t_cnt'(1);
        end else begin
            n_cnt = r_cnt;
        end
        n_touch = (n_cnt >= CNT_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_accept) begin
            r_cnt <= n_cnt;
        end
    end

    // touch flag rides along with the sort stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_LVL; k++) begin
            if (w_ctl.load[k]) begin
                r_tv[k] <= (k == 0) ? n_touch : r_tv[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // median lanes
    tpmd_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_sample_x),
        .o_median (w_res.median_x)
    );

    tpmd_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_sample_y),
        .o_median (w_res.median_y)
    );

    assign w_res.touch = r_tv[NUM_LVL-1];

    // merge and output register
    tpmd_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (r_vld[NUM_LVL-1]),
        .i_res         (w_res),
        .i_stall       (i_stall),
        .o_ready       (w_mrdy),
        .o_valid       (o_valid),
        .o_median_x    (o_median_x),
        .o_median_y    (o_median_y),
        .o_touch_valid (o_touch_valid)
    );

    // checks
    `TPMD_ASSERT_NEXT(a_cnt_clear, i_clk, i_rst_n, w_accept && !i_pen_down, r_cnt == '0)
    `TPMD_ASSERT_IMPLIES(a_cnt_limit, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_LIMIT)
    `TPMD_ASSERT_IMPLIES(a_stall_full, i_clk, i_rst_n, o_stall, (&r_vld) && !w_mrdy)
    `TPMD_ASSERT_NEXT(a_last_hold, i_clk, i_rst_n, r_vld[NUM_LVL-1] && !w_mrdy, r_vld[NUM_LVL-1])

endmodule

### hdl/tpmd_lane.sv
// ----------------------------------------------------------------------------
// tpmd_lane
// One sample history window with a pipelined compare-exchange sort, one
// network level per register stage; gives the median of the window.
// ----------------------------------------------------------------------------
module tpmd_lane import tpmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  t_sample   i_sample,
    output t_sample   o_median
);

    t_win r_win;
    t_win n_win;
    t_win r_lvl [NUM_LVL];
    t_win w_lvl_in [NUM_LVL];

    // oldest entry drops out, new sample enters at the top
    always_comb begin
        n_win                = r_win;
        n_win[WIN_DEPTH-2:0] = r_win[WIN_DEPTH-1:1];
        n_win[WIN_DEPTH-1]   = i_sample;
    end

    // history window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_ctl.shift) begin
            r_win <= n_win;
        end
    end

    // network level inputs: first level sorts the freshly shifted window
    always_comb begin
        w_lvl_in[0] = cx_level(n_win, t_lvl'(0));
        for (int k = 1; k < NUM_LVL; k++) begin
            w_lvl_in[k] = cx_level(r_lvl[k-1], t_lvl'(k));
        end
    end

    // sort stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_LVL; k++) begin
            if (i_ctl.load[k]) begin
                r_lvl[k] <= w_lvl_in[k];
            end
        end
    end

    assign o_median = r_lvl[NUM_LVL-1][MED_IDX];

endmodule

### hdl/tpmd_merge.sv
// ----------------------------------------------------------------------------
// tpmd_merge
// Joins the two lane medians and the touch flag into the output word and
// holds it in the output register until the consumer takes it.
// ----------------------------------------------------------------------------
module tpmd_merge import tpmd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_sample o_median_x,
    output t_sample o_median_y,
    output logic    o_touch_valid
);

    logic    r_vld;
    t_result r_res;

    // free when empty or when the held word leaves this cycle
    assign o_ready = !r_vld || !i_stall;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_res <= i_res;
        end
    end

    assign o_valid       = r_vld;
    assign o_median_x    = r_res.median_x;
    assign o_median_y    = r_res.median_y;
    assign o_touch_valid = r_res.touch;

endmodule
